// ===== rtl/cpr_pkg.sv =====
// ----------------------------------------------------------------------------
// cpr_pkg: shared types and constants for the clock page replacement core
// Field widths, reset values and the controller/datapath command and
// status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package cpr_pkg;

  localparam int FRAMES_DEF = 128;   // default frame table depth
  localparam int PAGE_BITS  = 16;    // page number width
  localparam int IDX_W      = 7;     // reported frame index width
  localparam int AF_W       = 8;     // active_frames register width
  localparam int CNT_W      = 32;    // hit counter width

  localparam logic [AF_W-1:0]  ACTIVE_RESET = AF_W'(128);
  localparam logic [CNT_W-1:0] CNT_MAX      = '1;

  // controller -> datapath
  typedef struct packed {
    logic load;          // take a new item
    logic search;        // step the match scan
    logic hit_commit;    // record a hit into the result register
    logic sweep_init;    // start the hand sweep
    logic sweep_step;    // clear the bit under the hand and advance
    logic evict_commit;  // fill the victim frame, record the miss result
    logic emit;          // move the result into the output register
  } cpr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic match;         // scan found the page
    logic miss;          // scan finished without a match
    logic clear_bit;     // frame under the hand has its bit clear
    logic out_free;      // output register can take a result
  } cpr_stat_t;

endpackage

`default_nettype wire

// ===== rtl/cpr_ifs.sv =====
// ----------------------------------------------------------------------------
// cpr channel interfaces
// Valid/ready channels for page references, results and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpr_access_if import cpr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

interface cpr_result_if import cpr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [IDX_W-1:0]     frame_index;
  logic                 evicted_valid;
  logic [PAGE_BITS-1:0] evicted_page;
  logic [CNT_W-1:0]     hit_total;

  modport source (output valid, output hit, output frame_index, output evicted_valid,
                  output evicted_page, output hit_total, input ready);
  modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                  input evicted_page, input hit_total, output ready);
endinterface

interface cpr_cfg_if import cpr_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [AF_W-1:0] active_frames;

  modport source (output valid, output active_frames, input ready);
  modport sink   (input valid, input active_frames, output ready);
endinterface

`default_nettype wire

// ===== rtl/cpr_ctrl.sv =====
// ----------------------------------------------------------------------------
// cpr_ctrl: sequencer for one page reference
// Walks idle -> match scan -> (hand sweep -> fill) -> result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module cpr_ctrl import cpr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  cpr_stat_t stat,
  output cpr_cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SEARCH = 5'b00010,
    ST_SWEEP  = 5'b00100,
    ST_EVICT  = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd.search = 1'b1;
        if (stat.match) begin
          cmd.hit_commit = 1'b1;
          state_next     = ST_DONE;
        end else if (stat.miss) begin
          cmd.sweep_init = 1'b1;
          state_next     = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        // memory read at the hand is issued this cycle when the bit is clear
        if (stat.clear_bit) begin
          state_next = ST_EVICT;
        end else begin
          cmd.sweep_step = 1'b1;
        end
      end
      ST_EVICT: begin
        cmd.evict_commit = 1'b1;
        state_next       = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/cpr_datapath.sv =====
// ----------------------------------------------------------------------------
// cpr_datapath: frame table, clock hand, hit counter and output register
// Page numbers sit in a one-read/one-write memory; valid and reference
// bits are flops so reset clears them at once.
// ----------------------------------------------------------------------------
`default_nettype none

module cpr_datapath import cpr_pkg::*; #(
  parameter int FRAMES = FRAMES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cpr_cmd_t             cmd,
  output cpr_stat_t            stat,
  input  logic [PAGE_BITS-1:0] page_number,
  input  logic                 cfg_we,
  input  logic [AF_W-1:0]      cfg_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 out_hit,
  output logic [IDX_W-1:0]     out_frame_index,
  output logic                 out_evicted_valid,
  output logic [PAGE_BITS-1:0] out_evicted_page,
  output logic [CNT_W-1:0]     out_hit_total
);

  localparam int AW = $clog2(FRAMES);
  localparam int NW = $clog2(FRAMES + 1);

  logic [PAGE_BITS-1:0] page_mem [FRAMES];
  logic [PAGE_BITS-1:0] rd_data;
  logic [AW-1:0]        rd_addr;

  logic [AF_W-1:0]      active_frames;
  logic [FRAMES-1:0]    valid_bits;
  logic [FRAMES-1:0]    ref_bits;
  logic [AW-1:0]        hand;
  logic [CNT_W-1:0]     hit_count;
  logic [CNT_W-1:0]     hit_inc;

  logic [PAGE_BITS-1:0] page;
  logic [NW-1:0]        scan_idx;
  logic [AW-1:0]        rd_idx;
  logic                 rd_live;
  logic [AW-1:0]        pos;
  logic [AW-1:0]        pos_wrap;
  logic [AW-1:0]        hand_start;
  logic [NW-1:0]        pos_inc;
  logic [NW-1:0]        n_eff;

  // result waiting for the output register
  logic                 res_hit;
  logic [IDX_W-1:0]     res_frame_index;
  logic                 res_evicted_valid;
  logic [PAGE_BITS-1:0] res_evicted_page;
  logic [CNT_W-1:0]     res_hit_total;

  // zero acts as one frame, anything above the table as the whole table
  always_comb begin
    if (active_frames == '0) begin
      n_eff = NW'(1);
    end else if (32'(active_frames) > 32'(FRAMES)) begin
      n_eff = NW'(FRAMES);
    end else begin
      n_eff = NW'(active_frames);
    end
  end

  assign hit_inc    = (hit_count == CNT_MAX) ? hit_count : hit_count + 1'b1;
  assign pos_inc    = NW'(pos) + 1'b1;
  assign pos_wrap   = (pos_inc >= n_eff) ? '0 : pos_inc[AW-1:0];
  assign hand_start = (NW'(hand) >= n_eff) ? '0 : hand;
  assign rd_addr    = cmd.search ? scan_idx[AW-1:0] : pos;

  assign stat.match     = rd_live && valid_bits[rd_idx] && (rd_data == page);
  assign stat.miss      = !rd_live && (scan_idx >= n_eff);
  assign stat.clear_bit = !ref_bits[pos];
  assign stat.out_free  = !out_valid || out_ready;

  // page memory
  always_ff @(posedge clk) begin
    rd_data <= page_mem[rd_addr];
    if (cmd.evict_commit) begin
      page_mem[pos] <= page;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      active_frames <= ACTIVE_RESET;
      valid_bits    <= '0;
      ref_bits      <= '0;
      hand          <= '0;
      hit_count     <= '0;
      scan_idx      <= '0;
      rd_live       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        active_frames <= cfg_data;
      end
      if (cmd.load) begin
        scan_idx <= '0;
        rd_live  <= 1'b0;
      end else if (cmd.search) begin
        if (scan_idx < n_eff) begin
          scan_idx <= scan_idx + 1'b1;
          rd_live  <= 1'b1;
        end else begin
          rd_live  <= 1'b0;
        end
      end
      if (cmd.hit_commit) begin
        ref_bits[rd_idx] <= 1'b1;
        hit_count        <= hit_inc;
      end
      if (cmd.sweep_step) begin
        ref_bits[pos] <= 1'b0;
      end
      if (cmd.evict_commit) begin
        valid_bits[pos] <= 1'b1;
        ref_bits[pos]   <= 1'b1;
        hand            <= pos_wrap;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page <= page_number;
    end
    if (cmd.search) begin
      rd_idx <= scan_idx[AW-1:0];
    end
    if (cmd.sweep_init) begin
      pos <= hand_start;
    end else if (cmd.sweep_step) begin
      pos <= pos_wrap;
    end
    if (cmd.hit_commit) begin
      res_hit           <= 1'b1;
      res_frame_index   <= IDX_W'(rd_idx);
      res_evicted_valid <= 1'b0;
      res_evicted_page  <= '0;
      res_hit_total     <= hit_inc;
    end else if (cmd.evict_commit) begin
      res_hit           <= 1'b0;
      res_frame_index   <= IDX_W'(pos);
      res_evicted_valid <= valid_bits[pos];
      res_evicted_page  <= valid_bits[pos] ? rd_data : '0;
      res_hit_total     <= hit_count;
    end
    if (cmd.emit) begin
      out_hit           <= res_hit;
      out_frame_index   <= res_frame_index;
      out_evicted_valid <= res_evicted_valid;
      out_evicted_page  <= res_evicted_page;
      out_hit_total     <= res_hit_total;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/clock_page_replacement_core.sv =====
// ----------------------------------------------------------------------------
// clock_page_replacement_core: clock (second-chance) page replacement
// Top level joining the sequencer and the frame table datapath.
// ----------------------------------------------------------------------------
// One page reference is taken at a time. The frame table is scanned one
// frame per cycle through the single read port of the page memory, and a
// hit stops the scan at the matching frame. A miss scans all n active
// frames, then the hand sweeps one frame per cycle until it meets a clear
// reference bit, visiting at most n + 1 frames; then the frame is filled
// and the result is handed to the output register once that register is
// free. A result waiting in the output register does not stop the next
// reference from being taken and processed. active_frames is taken on the
// cfg port whenever it is offered and should only be written while no
// reference is in flight; zero acts as one frame and values above FRAMES
// as FRAMES.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_page_replacement_core import cpr_pkg::*; #(
  parameter int FRAMES = FRAMES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  cpr_cfg_if.sink       cfg,
  cpr_access_if.sink    access,
  cpr_result_if.source  result
);

  cpr_cmd_t  cmd;
  cpr_stat_t stat;
  logic      in_ready;

  assign cfg.ready    = 1'b1;
  assign access.ready = in_ready;

  cpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (access.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cpr_datapath #(
    .FRAMES (FRAMES)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .page_number       (access.page_number),
    .cfg_we            (cfg.valid),
    .cfg_data          (cfg.active_frames),
    .out_ready         (result.ready),
    .out_valid         (result.valid),
    .out_hit           (result.hit),
    .out_frame_index   (result.frame_index),
    .out_evicted_valid (result.evicted_valid),
    .out_evicted_page  (result.evicted_page),
    .out_hit_total     (result.hit_total)
  );

endmodule

`default_nettype wire

// ===== rtl/cpr_checker.sv =====
// ----------------------------------------------------------------------------
// cpr_checker: port-level checks for the clock page replacement core
// Tracks the hit total of the last delivered result.
// ----------------------------------------------------------------------------
`default_nettype none

module cpr_checker import cpr_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 hit,
  input logic [IDX_W-1:0]     frame_index,
  input logic                 evicted_valid,
  input logic [PAGE_BITS-1:0] evicted_page,
  input logic [CNT_W-1:0]     hit_total
);

  logic [CNT_W-1:0] last_total;
  logic [CNT_W-1:0] exp_inc;

  assign exp_inc = (last_total == CNT_MAX) ? last_total : last_total + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_total <= '0;
    end else if (out_valid && out_ready) begin
      last_total <= hit_total;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(frame_index) &&
      $stable(evicted_valid) && $stable(evicted_page) && $stable(hit_total))
    else $error("result changed while stalled");

  // one reference at a time: taking an item drops ready
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken back to back");

  a_hit_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> hit_total == exp_inc)
    else $error("hit total did not advance on a hit");

  a_miss_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> hit_total == last_total)
    else $error("hit total moved on a miss");

  a_evict_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (hit || !evicted_valid) |-> evicted_page == '0 && !(hit && evicted_valid))
    else $error("eviction reported without a replaced page");

endmodule

bind clock_page_replacement_core cpr_checker u_cpr_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (access.valid),
  .in_ready      (access.ready),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .hit           (result.hit),
  .frame_index   (result.frame_index),
  .evicted_valid (result.evicted_valid),
  .evicted_page  (result.evicted_page),
  .hit_total     (result.hit_total)
);

`default_nettype wire
